/* rtl/tqs_pkg.sv */
package tqs_pkg;

    // Item opcodes
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_ENQ  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Register indexes on the configuration channel
    localparam logic [2:0] CFG_BEEPER_LEVEL    = 3'd0;
    localparam logic [2:0] CFG_SPEAKER_MODE    = 3'd1;
    localparam logic [2:0] CFG_SPEAKER_PITCH   = 3'd2;
    localparam logic [2:0] CFG_HAPTIC_STRENGTH = 3'd3;
    localparam logic [2:0] CFG_BEEP_OFFSET     = 3'd4;

    // Buzzer level codes
    localparam logic [2:0] LVL_MUTE   = 3'd0;
    localparam logic [2:0] LVL_XSHORT = 3'd2;
    localparam logic [2:0] LVL_SHORT  = 3'd3;
    localparam logic [2:0] LVL_NORM   = 3'd4;
    localparam logic [2:0] LVL_LONG   = 3'd5;
    localparam logic [2:0] LVL_XLONG  = 3'd6;

    // Speaker modes
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_SQUARE = 2'd1;

    localparam logic [7:0] PHASE_MSB_MASK = 8'h80;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    typedef struct packed {
        logic       hap;
        logic [7:0] rep;
        logic [7:0] pause;
        logic [7:0] dur;
        logic [7:0] end_f;
        logic [7:0] start_f;
    } t_slot;

    typedef struct packed {
        t_op   op;
        t_slot slot;
    } t_req;

    typedef struct packed {
        logic accepted;
        logic haptic;
        logic buzzer;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

/* rtl/tqs_ctrl.sv */
module tqs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output tqs_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.exec  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait for room in the output register
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.exec))
        else $error("load and exec issued together");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_m_tvalid)
        else $error("result not presented after exec");

    a_load_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_EXEC))
        else $error("loaded item not moved to exec");
`endif

endmodule

/* rtl/tqs_dp.sv */
module tqs_dp #(
    parameter int QUEUE_DEPTH = 8,
    parameter int DIV_XSHORT  = 5,
    parameter int DIV_SHORT   = 10,
    parameter int DIV_NORM    = 20,
    parameter int DIV_LONG    = 40,
    parameter int DIV_XLONG   = 80
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tqs_pkg::t_cmd                      i_cmd,
    input  logic [tqs_pkg::IN_TUSER_W-1:0]     i_op,
    input  logic [tqs_pkg::IN_TDATA_W-1:0]     i_item,
    input  logic                               i_cfg_we,
    input  logic [tqs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tqs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tqs_pkg::t_result                   o_result
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    // configuration
    logic [2:0] r_level;
    logic [1:0] r_mode;
    logic [7:0] r_pitch;
    logic [7:0] r_strength;
    logic [7:0] r_offset;

    // latched item
    tqs_pkg::t_req r_req;

    // queue and tone state
    tqs_pkg::t_slot r_slot [QUEUE_DEPTH];
    tqs_pkg::t_slot n_slot [QUEUE_DEPTH];
    logic [7:0] r_cur_freq,  n_cur_freq;
    logic [7:0] r_time_left, n_time_left;
    logic [7:0] r_pause_left, n_pause_left;
    logic [7:0] r_repeat_left, n_repeat_left;
    logic       r_repeating, n_repeating;
    logic       r_sweep_on,  n_sweep_on;
    logic       r_sweep_up,  n_sweep_up;
    logic       r_motor_on,  n_motor_on;
    logic       r_playing,   n_playing;
    logic [7:0] r_haptic_ticks, n_haptic_ticks;
    logic [7:0] r_div_count, n_div_count;
    logic [7:0] r_phase, n_phase;
    logic       r_buzz, n_buzz;
    logic       r_hap,  n_hap;
    tqs_pkg::t_result r_result, n_result;

    logic [7:0]       div_limit;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             do_shift;
    tqs_pkg::t_slot   head;

    always_comb begin
        case (r_level)
            tqs_pkg::LVL_XSHORT: div_limit = 8'(DIV_XSHORT);
            tqs_pkg::LVL_SHORT:  div_limit = 8'(DIV_SHORT);
            tqs_pkg::LVL_LONG:   div_limit = 8'(DIV_LONG);
            tqs_pkg::LVL_XLONG:  div_limit = 8'(DIV_XLONG);
            default:             div_limit = 8'(DIV_NORM);
        endcase
    end

    // first slot with a zero start frequency
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!free_found && r_slot[i].start_f == 8'd0) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    assign head = r_slot[0];

    always_comb begin
        n_slot         = r_slot;
        n_cur_freq     = r_cur_freq;
        n_time_left    = r_time_left;
        n_pause_left   = r_pause_left;
        n_repeat_left  = r_repeat_left;
        n_repeating    = r_repeating;
        n_sweep_on     = r_sweep_on;
        n_sweep_up     = r_sweep_up;
        n_motor_on     = r_motor_on;
        n_playing      = r_playing;
        n_haptic_ticks = r_haptic_ticks;
        n_div_count    = r_div_count;
        n_phase        = r_phase;
        n_buzz         = r_buzz;
        n_hap          = r_hap;
        do_shift       = 1'b0;
        n_result.accepted = 1'b0;

        case (r_req.op)
            tqs_pkg::OP_TICK: begin
                // drive pins from the tone in progress
                if (r_playing) begin
                    if (r_level != tqs_pkg::LVL_MUTE) begin
                        if (r_mode == tqs_pkg::MODE_PLAIN) begin
                            n_buzz = (r_time_left != 8'd0);
                        end else if (r_mode == tqs_pkg::MODE_SQUARE) begin
                            if (r_time_left != 8'd0) begin
                                n_phase = r_phase + r_cur_freq;
                                n_buzz  = (n_phase & tqs_pkg::PHASE_MSB_MASK) != 8'd0;
                            end else begin
                                n_buzz = 1'b0;
                            end
                        end
                    end
                    if (r_motor_on) begin
                        if (r_strength != 8'd0 && r_haptic_ticks < r_strength) begin
                            n_hap          = 1'b1;
                            n_haptic_ticks = r_haptic_ticks + 8'd1;
                        end else begin
                            n_hap          = 1'b0;
                            n_haptic_ticks = 8'd0;
                        end
                    end else begin
                        n_hap = 1'b0;
                    end
                end else begin
                    n_buzz = 1'b0;
                    n_hap  = 1'b0;
                end

                // start the head tone when idle
                if ((head.start_f != 8'd0 || head.hap) && r_time_left == 8'd0 &&
                    !r_playing) begin
                    if (head.end_f != 8'd0 && head.end_f != head.start_f) begin
                        if (head.start_f > head.end_f) begin
                            n_time_left = head.start_f - head.end_f;
                            n_sweep_up  = 1'b0;
                        end else begin
                            n_time_left = head.end_f - head.start_f;
                            n_sweep_up  = 1'b1;
                        end
                        n_cur_freq = head.start_f + r_pitch;
                        n_sweep_on = 1'b1;
                    end else begin
                        n_cur_freq  = head.start_f + r_pitch + r_offset;
                        n_sweep_on  = 1'b0;
                        n_sweep_up  = 1'b0;
                        n_time_left = head.dur;
                    end
                    n_pause_left = head.pause;
                    n_motor_on   = head.hap;
                    n_playing    = 1'b1;

                    if (head.rep != 8'd0 && !r_repeating) begin
                        n_repeating   = 1'b1;
                        n_repeat_left = head.rep;
                    end
                    if (n_repeating) begin
                        n_repeat_left = n_repeat_left - 8'd1;
                        if (n_repeat_left == 8'd0) begin
                            n_repeating = 1'b0;
                            do_shift    = 1'b1;
                        end
                    end else begin
                        do_shift = 1'b1;
                    end
                end

                if (do_shift) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        n_slot[i] = r_slot[i+1];
                    end
                    n_slot[QUEUE_DEPTH-1] = '0;
                end

                // divided tick: tone time, sweep step, pause
                n_div_count = r_div_count + 8'd1;
                if (n_div_count >= div_limit) begin
                    n_div_count = 8'd0;
                    if (n_time_left != 8'd0 && n_playing) begin
                        if (n_sweep_on) begin
                            n_cur_freq = n_sweep_up ? n_cur_freq + 8'd1 : n_cur_freq - 8'd1;
                        end
                        n_time_left = n_time_left - 8'd1;
                    end
                    if (n_time_left == 8'd0 && n_playing) begin
                        if (n_pause_left == 8'd0) begin
                            n_playing = 1'b0;
                        end else begin
                            n_pause_left = n_pause_left - 8'd1;
                        end
                    end
                end
            end
            tqs_pkg::OP_PLAY: begin
                n_slot[0]         = r_req.slot;
                n_result.accepted = 1'b1;
            end
            tqs_pkg::OP_ENQ: begin
                if (free_found) begin
                    n_slot[free_idx]  = r_req.slot;
                    n_result.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_result.buzzer = n_buzz;
        n_result.haptic = n_hap;
    end

    // item latch and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req.op           <= tqs_pkg::t_op'(i_op);
            r_req.slot.start_f <= i_item[7:0];
            r_req.slot.end_f   <= i_item[15:8];
            r_req.slot.dur     <= i_item[23:16];
            r_req.slot.pause   <= i_item[31:24];
            r_req.slot.rep     <= i_item[39:32];
            r_req.slot.hap     <= i_item[40];
        end
        if (i_cmd.exec) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slot[i] <= '0;
            end
            r_cur_freq     <= 8'd0;
            r_time_left    <= 8'd0;
            r_pause_left   <= 8'd0;
            r_repeat_left  <= 8'd0;
            r_repeating    <= 1'b0;
            r_sweep_on     <= 1'b0;
            r_sweep_up     <= 1'b0;
            r_motor_on     <= 1'b0;
            r_playing      <= 1'b0;
            r_haptic_ticks <= 8'd0;
            r_div_count    <= 8'd0;
            r_phase        <= 8'd0;
            r_buzz         <= 1'b0;
            r_hap          <= 1'b0;
        end else if (i_cmd.exec) begin
            r_slot         <= n_slot;
            r_cur_freq     <= n_cur_freq;
            r_time_left    <= n_time_left;
            r_pause_left   <= n_pause_left;
            r_repeat_left  <= n_repeat_left;
            r_repeating    <= n_repeating;
            r_sweep_on     <= n_sweep_on;
            r_sweep_up     <= n_sweep_up;
            r_motor_on     <= n_motor_on;
            r_playing      <= n_playing;
            r_haptic_ticks <= n_haptic_ticks;
            r_div_count    <= n_div_count;
            r_phase        <= n_phase;
            r_buzz         <= n_buzz;
            r_hap          <= n_hap;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level    <= tqs_pkg::LVL_NORM;
            r_mode     <= tqs_pkg::MODE_PLAIN;
            r_pitch    <= 8'd0;
            r_strength <= 8'd0;
            r_offset   <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tqs_pkg::CFG_BEEPER_LEVEL:    r_level    <= i_cfg_data[2:0];
                tqs_pkg::CFG_SPEAKER_MODE:    r_mode     <= i_cfg_data[1:0];
                tqs_pkg::CFG_SPEAKER_PITCH:   r_pitch    <= i_cfg_data;
                tqs_pkg::CFG_HAPTIC_STRENGTH: r_strength <= i_cfg_data;
                tqs_pkg::CFG_BEEP_OFFSET:     r_offset   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_result = r_result;

`ifndef SYNTH
    a_time_needs_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_time_left != 8'd0) |-> r_playing)
        else $error("tone time left while not playing");

    a_repeat_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_repeating |-> (r_repeat_left == 8'd0))
        else $error("repeat count left without repeat run");
`endif

endmodule

/* rtl/tone_queue_sequencer.sv */
// Channel  Dir  Handshake                          Payload
// s_axis   in   i_s_axis_tvalid / o_s_axis_tready  tuser: opcode; tdata: tone request
// m_axis   out  o_m_axis_tvalid / i_m_axis_tready  tdata: buzzer_out, haptic_out, accepted
// cfg      in   i_cfg_valid / o_cfg_ready          index 0..4, 8-bit data
//
// Each item is registered while the controller is idle, then the controller's execute
// step performs the whole tick, play or enqueue update on the tone state.
// Reset (i_rst_n low, synchronous) clears queue, tone and pin state, resets config.
// While a result waits in the output register the next item is still taken; its
// execute step holds until the output register drains.
// Configuration writes are always ready and take effect on the next cycle.
module tone_queue_sequencer #(
    parameter int QUEUE_DEPTH = 8,
    parameter int DIV_XSHORT  = 5,
    parameter int DIV_SHORT   = 10,
    parameter int DIV_NORM    = 20,
    parameter int DIV_LONG    = 40,
    parameter int DIV_XLONG   = 80
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // [7:0] start_freq, [15:8] end_freq, [23:16] duration, [31:24] pause_len,
    // [39:32] repeat_num, [40] haptic_req, [47:41] zero
    input  logic [tqs_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [1:0] opcode
    input  logic [tqs_pkg::IN_TUSER_W-1:0]    i_s_axis_tuser,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [0] buzzer_out, [1] haptic_out, [2] accepted, [7:3] zero
    output logic [tqs_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tqs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tqs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tqs_pkg::t_cmd    cmd;
    tqs_pkg::t_result result;

    // Register file never stalls.
    assign o_cfg_ready = 1'b1;

    tqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_cmd      (cmd)
    );

    tqs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DIV_XSHORT  (DIV_XSHORT),
        .DIV_SHORT   (DIV_SHORT),
        .DIV_NORM    (DIV_NORM),
        .DIV_LONG    (DIV_LONG),
        .DIV_XLONG   (DIV_XLONG)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_op        (i_s_axis_tuser),
        .i_item      (i_s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (result)
    );

    // Pack result fields, lowest bit first.
    assign o_m_axis_tdata = {5'd0, result.accepted, result.haptic, result.buzzer};

endmodule
